[rtl/sb2da_pkg.sv]
// Shared types and constants of the signed binary to decimal ASCII formatter.
package sb2da_pkg;

    localparam int DIGIT_W = 4;
    localparam int CHAR_W  = 7;

    localparam logic [CHAR_W-1:0] CODE_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0] CODE_MINUS = 7'd45;

    typedef struct packed {
        logic clear;
        logic dabble;
        logic digit_shift;
    } cell_ctrl_t;

endpackage

[rtl/signed_binary_to_decimal_ascii.sv]
// Top level: signed integer in, decimal ASCII characters out through a digit cell chain.
//
//  Channel | Ports                         | Beat contents
//  --------+-------------------------------+------------------------------------------
//  input   | s_tvalid, s_tready, s_tdata   | value (64 bits, low VALUE_WIDTH used)
//  output  | m_tvalid, m_tready, m_tdata,  | char_code in m_tdata, last_char on m_tlast
//          | m_tlast                       |
//
// A number goes through an accept step, a bit-serial conversion of its VALUE_WIDTH bits
// through the digit cells, a minus sign if it is negative, a skip over the leading zeros
// to reach the first digit, and one character per digit sent; a new number is accepted
// only once the state machine is back in idle after its last digit.
// Reset clears the control state; the digit cells need no reset.
// A stall on the output holds the character register, and while characters are sent the cell chain, in place.
module signed_binary_to_decimal_ascii #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [6:0] char_code, [7] zero
    output logic        m_tlast    // last_char
);

    localparam int NUM_DIGITS = (((VALUE_WIDTH - 1) * 1233) >> 12) + 1;
    localparam int BCW        = $clog2(VALUE_WIDTH);
    localparam int DCW        = $clog2(NUM_DIGITS + 1);
    localparam int DW         = sb2da_pkg::DIGIT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_SIGN,
        ST_SKIP,
        ST_EMIT
    } state_t;

    state_t                          state_reg, state_next;
    logic                            neg_reg, neg_next;
    logic [VALUE_WIDTH-1:0]          mag_reg, mag_next;
    logic [BCW-1:0]                  bit_cnt_reg, bit_cnt_next;
    logic [DCW-1:0]                  dig_cnt_reg, dig_cnt_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [sb2da_pkg::CHAR_W-1:0]    char_reg, char_next;
    logic                            m_tlast_reg, m_tlast_next;

    sb2da_pkg::cell_ctrl_t           ctrl;
    logic [NUM_DIGITS:0]             carry;
    logic [DW-1:0]                   digits [NUM_DIGITS];
    logic [VALUE_WIDTH-1:0]          x_in;
    logic                            out_free;
    logic [DW-1:0]                   top_digit;

    assign x_in      = s_tdata[VALUE_WIDTH-1:0];
    assign out_free  = !m_tvalid_reg || m_tready;
    assign top_digit = digits[NUM_DIGITS-1];
    assign carry[0]  = mag_reg[VALUE_WIDTH-1];

    genvar gi;
    generate
        for (gi = 0; gi < NUM_DIGITS; gi++) begin : g_cell
            logic [DW-1:0] d_in;
            if (gi == 0) begin : g_first
                assign d_in = '0;
            end else begin : g_rest
                assign d_in = digits[gi-1];
            end
            sb2da_cell u_cell (
                .aclk      (aclk),
                .ctrl      (ctrl),
                .bit_in    (carry[gi]),
                .bit_out   (carry[gi+1]),
                .digit_in  (d_in),
                .digit_out (digits[gi])
            );
        end
    endgenerate

    always_comb begin
        state_next    = state_reg;
        neg_next      = neg_reg;
        mag_next      = mag_reg;
        bit_cnt_next  = bit_cnt_reg;
        dig_cnt_next  = dig_cnt_reg;
        m_tvalid_next = m_tvalid_reg;
        char_next     = char_reg;
        m_tlast_next  = m_tlast_reg;
        ctrl          = '0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    neg_next     = x_in[VALUE_WIDTH-1];
                    mag_next     = x_in[VALUE_WIDTH-1] ? (~x_in + 1'b1) : x_in;
                    bit_cnt_next = BCW'(VALUE_WIDTH - 1);
                    dig_cnt_next = DCW'(NUM_DIGITS);
                    ctrl.clear   = 1'b1;
                    state_next   = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                ctrl.dabble  = 1'b1;
                mag_next     = {mag_reg[VALUE_WIDTH-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == '0) begin
                    state_next = neg_reg ? ST_SIGN : ST_SKIP;
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    char_next     = sb2da_pkg::CODE_MINUS;
                    m_tlast_next  = 1'b0;
                    state_next    = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (top_digit == '0 && dig_cnt_reg != DCW'(1)) begin
                    ctrl.digit_shift = 1'b1;
                    dig_cnt_next     = dig_cnt_reg - 1'b1;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_tvalid_next    = 1'b1;
                    char_next        = sb2da_pkg::CODE_ZERO + sb2da_pkg::CHAR_W'(top_digit);
                    m_tlast_next     = (dig_cnt_reg == DCW'(1));
                    ctrl.digit_shift = 1'b1;
                    dig_cnt_next     = dig_cnt_reg - 1'b1;
                    if (dig_cnt_reg == DCW'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        neg_reg     <= neg_next;
        mag_reg     <= mag_next;
        bit_cnt_reg <= bit_cnt_next;
        dig_cnt_reg <= dig_cnt_next;
        char_reg    <= char_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, char_reg};
    assign m_tlast  = m_tlast_reg;

endmodule

[rtl/sb2da_cell.sv]
// One decimal digit cell of the shift-and-add-three conversion chain.
module sb2da_cell (
    input  logic                              aclk,
    input  sb2da_pkg::cell_ctrl_t             ctrl,
    input  logic                              bit_in,
    output logic                              bit_out,
    input  logic [sb2da_pkg::DIGIT_W-1:0]     digit_in,
    output logic [sb2da_pkg::DIGIT_W-1:0]     digit_out
);

    logic [sb2da_pkg::DIGIT_W-1:0] digit_reg;
    logic [sb2da_pkg::DIGIT_W-1:0] digit_next;
    logic [sb2da_pkg::DIGIT_W-1:0] corr;

    assign corr      = (digit_reg >= 4'd5) ? (digit_reg + 4'd3) : digit_reg;
    assign bit_out   = corr[sb2da_pkg::DIGIT_W-1];
    assign digit_out = digit_reg;

    always_comb begin
        digit_next = digit_reg;
        if (ctrl.clear) begin
            digit_next = '0;
        end else if (ctrl.dabble) begin
            digit_next = {corr[sb2da_pkg::DIGIT_W-2:0], bit_in};
        end else if (ctrl.digit_shift) begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge aclk) begin
        digit_reg <= digit_next;
    end

endmodule

[verif/sb2da_checker.sv]
`timescale 1ns / 100ps
// Checker that predicts the decimal ASCII text of each accepted number and compares each beat.
module sb2da_checker #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] value
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // [6:0] char_code, [7] zero
    input  logic        m_tlast,   // last_char
    output int          errors,
    output int          pending,
    output int          numbers_seen,
    output int          chars_checked
);

    localparam int          RADIX      = 10;
    localparam int          MAX_DIGITS = 20;
    localparam int          REPORT_MAX = 10;
    localparam logic [63:0] WIDTH_MASK = {64{1'b1}} >> (64 - VALUE_WIDTH);

    typedef struct packed {
        logic [sb2da_pkg::CHAR_W-1:0] code;
        logic                         last;
    } ascii_char_t;

    ascii_char_t expected_chars[$];

    function automatic void queue_decimal_text(input logic [63:0] raw);
        logic [63:0]                   x;
        logic [63:0]                   mag;
        logic                          negative;
        logic [sb2da_pkg::DIGIT_W-1:0] digits[MAX_DIGITS];
        int                            count;
        ascii_char_t                   ch;
        x        = raw & WIDTH_MASK;
        negative = x[VALUE_WIDTH-1];
        mag      = negative ? ((~x + 64'd1) & WIDTH_MASK) : x;
        count    = 0;
        do begin
            digits[count] = sb2da_pkg::DIGIT_W'(mag % RADIX);
            mag           = mag / RADIX;
            count++;
        end while (mag != 0 && count < MAX_DIGITS);
        if (negative) begin
            ch.code = sb2da_pkg::CODE_MINUS;
            ch.last = 1'b0;
            expected_chars.push_back(ch);
        end
        for (int i = count - 1; i >= 0; i--) begin
            ch.code = sb2da_pkg::CODE_ZERO + sb2da_pkg::CHAR_W'(digits[i]);
            ch.last = (i == 0);
            expected_chars.push_back(ch);
        end
    endfunction

    always @(posedge aclk) begin : watch
        ascii_char_t due;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                queue_decimal_text(s_tdata);
                numbers_seen++;
            end
            if (m_tvalid && m_tready) begin
                chars_checked++;
                if (expected_chars.size() == 0) begin
                    errors++;
                    if (errors <= REPORT_MAX) begin
                        $display("[%0t] unexpected beat: code %0d last %0b", $realtime,
                                 m_tdata[6:0], m_tlast);
                    end
                end else begin
                    due = expected_chars.pop_front();
                    if (m_tdata[6:0] !== due.code || m_tlast !== due.last ||
                        m_tdata[7] !== 1'b0) begin
                        errors++;
                        if (errors <= REPORT_MAX) begin
                            $display({"[%0t] beat %0d: expected code %0d last %0b, ",
                                      "got code %0d last %0b pad %0b"},
                                     $realtime, chars_checked, due.code, due.last,
                                     m_tdata[6:0], m_tlast, m_tdata[7]);
                        end
                    end
                end
            end
            pending = expected_chars.size();
        end
    end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// Top of the formatter testbench: clock, reset, stimulus, output stalls and the verdict.
module tb_top;

    localparam int RANDOM_ITEMS = 110;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 600000;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    int errors;
    int pending;
    int numbers_seen;
    int chars_checked;
    int items_sent = 0;
    int cycles     = 0;

    signed_binary_to_decimal_ascii #(.VALUE_WIDTH(64)) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    sb2da_checker #(.VALUE_WIDTH(64)) u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .errors        (errors),
        .pending       (pending),
        .numbers_seen  (numbers_seen),
        .chars_checked (chars_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("signed_binary_to_decimal_ascii test failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(15, 40);
    endfunction

    function automatic logic [63:0] random_value();
        logic [63:0] v;
        int          bits;
        int          r;
        r = $urandom_range(0, 99);
        v = {$urandom, $urandom};
        if (r < 60) begin
            bits = $urandom_range(1, 64);
            if (bits < 64) begin
                v = v & ((64'd1 << bits) - 64'd1);
            end
        end else if (r < 75) begin
            v = 64'd1;
            repeat ($urandom_range(0, 18)) v = v * 64'd10;
            v = v + 64'($urandom_range(0, 2)) - 64'd1;
        end
        if (r < 75 && $urandom_range(0, 1) == 1) begin
            v = -v;
        end
        return v;
    endfunction

    task automatic send_beat(input logic [63:0] v);
        int gap;
        gap      = (items_sent >= 70 && items_sent < 100) ? 0 : pick_gap();
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= {$urandom, $urandom};
            repeat (gap) @(posedge aclk);
        end
    endtask

    // The receiver holds off once for a long stretch so the block backs up its input.
    initial begin : receiver
        int  low_left;
        int  r;
        bit  held;
        low_left = 0;
        held     = 1'b0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (!held && items_sent >= 30) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (items_sent >= 70 && items_sent < 100) begin
                m_tready <= 1'b1;
            end else if (low_left > 0) begin
                low_left--;
                m_tready <= 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    m_tready <= 1'b1;
                end else begin
                    m_tready <= 1'b0;
                    low_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(15, 40);
                end
            end
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        send_beat(64'd0);
        send_beat(64'd1);
        send_beat(64'hFFFF_FFFF_FFFF_FFFF);
        send_beat(64'd9);
        send_beat(64'd10);
        send_beat(-64'd10);
        send_beat(64'd99);
        send_beat(64'd100);
        send_beat(-64'd7);
        send_beat(64'h7FFF_FFFF_FFFF_FFFF);
        send_beat(64'h8000_0000_0000_0000);
        send_beat(64'h8000_0000_0000_0001);
        send_beat(64'd999999999999999999);
        send_beat(64'd1000000000000000000);
        send_beat(-64'd1000000000000000000);
        send_beat(64'h5555_5555_5555_5555);
        send_beat(64'hAAAA_AAAA_AAAA_AAAA);
        send_beat(64'd12345);
        send_beat(-64'd12345);
        send_beat(64'h0000_0000_FFFF_FFFF);
        send_beat(64'hFFFF_FFFF_0000_0000);
        send_beat(64'd1234567890123456789);

        repeat (RANDOM_ITEMS) send_beat(random_value());
        s_tvalid <= 1'b0;
        @(posedge aclk);

        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display({"Covered %0d numbers: zero, both signs, both 64-bit extremes, ",
                  "powers of ten and random magnitudes of 1 to 64 bits."},
                 numbers_seen);
        $display({"Checked %0d characters under random stalls on both sides ",
                  "and a %0d-cycle output hold-off."},
                 chars_checked, HOLD_CYCLES);
        if (errors == 0 && pending == 0) begin
            $display("signed_binary_to_decimal_ascii test passed");
        end else begin
            $display("signed_binary_to_decimal_ascii test failed");
        end
        $finish;
    end

endmodule
